[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the Collatz pack search block.
// Included by bare file name; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is low.
`define CPMS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cpms assertion failed");

// Concurrent assertion that is checked only while reset is low.
`define CPMS_ASSERT_IN_RESET(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) !rstn |-> prop) \
    else $error("cpms reset assertion failed");

`endif

[rtl/cpms_pkg.sv]
// Package of the Collatz pack search block: field widths, fixed constants,
// state and operation codes, and the status struct of the series engine.
// Depends on nothing; used by every module of the block.
package cpms_pkg;

  localparam int unsigned DIGIT_W   = 8;
  localparam int unsigned START_W   = 32;
  localparam int unsigned IDX_W     = 33;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned LEN_OUT_W = 16;
  localparam int unsigned SEED_W    = 34;
  localparam int unsigned HEIGHT_W  = 63;

  localparam logic [CNT_W-1:0] CNT_RESET = 11'd100;
  localparam logic [CNT_W-1:0] CNT_MAX   = 11'd1024;

  typedef enum logic [2:0] {
    SER_IDLE   = 3'b001,
    SER_PASS   = 3'b010,
    SER_DECIDE = 3'b100
  } ser_state_e;

  typedef enum logic [1:0] {
    OP_COPY   = 2'd0,
    OP_HALF   = 2'd1,
    OP_TRIPLE = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_RUN  = 5'b00010,
    T_CMP  = 5'b00100,
    T_UPD  = 5'b01000,
    T_DONE = 5'b10000
  } top_state_e;

  typedef struct packed {
    logic done;
    logic ovf;
  } ser_stat_t;

endpackage

[rtl/cpms_series.sv]
// Digit-serial Collatz series engine: runs one seed to 1 or until it is cut short, and
// reports its length and peak. Depends on cpms_pkg.
module cpms_series #(
  parameter int unsigned VALUE_WIDTH  = 64,
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [cpms_pkg::SEED_W-1:0]           seed_i,
  output cpms_pkg::ser_stat_t                   stat_o,
  output logic [LENGTH_WIDTH-1:0]               len_o,
  output logic [(VALUE_WIDTH+cpms_pkg::DIGIT_W-2)/cpms_pkg::DIGIT_W-1:0]
               [cpms_pkg::DIGIT_W-1:0]          peak_o
);
  import cpms_pkg::*;

  localparam int unsigned VW_N   = VALUE_WIDTH - 1;
  localparam int unsigned NDIG   = (VW_N + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned PW     = NDIG * DIGIT_W;
  localparam int unsigned DIG_IW = $clog2(NDIG);
  localparam logic [DIG_IW-1:0] LAST = DIG_IW'(NDIG - 1);

  // Largest value for which 3n+1 still fits the value range.
  localparam logic [PW:0]   ONE_X  = (PW+1)'(1);
  localparam logic [PW:0]   VLIM_X = (ONE_X << VW_N) - ONE_X;
  localparam logic [PW-1:0] CLIM   = PW'((VLIM_X - ONE_X) / 3);
  localparam logic [NDIG-1:0][DIGIT_W-1:0] CLIM_D = CLIM;

  ser_state_e                  state_q, state_d;
  op_e                         op_q, op_d;
  logic [DIG_IW-1:0]           dig_q, dig_d;
  logic [1:0]                  carry_q, carry_d;
  logic                        pmsb_q, pmsb_d;
  logic                        gtt_q, gtt_d;
  logic                        gtc_q, gtc_d;
  logic                        nzhi_q, nzhi_d;
  logic                        lowone_q, lowone_d;
  logic                        lsb_q, lsb_d;
  logic                        ovf_q, ovf_d;
  logic                        done_q, done_d;
  logic [NDIG-1:0][DIGIT_W-1:0] n_q, n_d;
  logic [NDIG-1:0][DIGIT_W-1:0] top_q, top_d;
  logic [LENGTH_WIDTH-1:0]     steps_q, steps_d;

  logic [DIGIT_W-1:0]   d0, dbl, out_dig;
  logic                 hb, first;
  logic [DIGIT_W+1:0]   sum;
  logic                 gtt_b, gtc_b;

  // One digit of the next value, least significant digit first.
  always_comb begin
    d0    = n_q[0];
    hb    = (dig_q == LAST) ? 1'b0 : n_q[1][0];
    dbl   = {d0[DIGIT_W-2:0], pmsb_q};
    sum   = (DIGIT_W+2)'(d0) + (DIGIT_W+2)'(dbl) + (DIGIT_W+2)'(carry_q);
    first = (dig_q == '0);
    case (op_q)
      OP_COPY:   out_dig = d0;
      OP_HALF:   out_dig = {hb, d0[DIGIT_W-1:1]};
      OP_TRIPLE: out_dig = sum[DIGIT_W-1:0];
      default:   out_dig = d0;
    endcase
    gtt_b = first ? 1'b0 : gtt_q;
    gtc_b = first ? 1'b0 : gtc_q;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    dig_d    = dig_q;
    carry_d  = carry_q;
    pmsb_d   = pmsb_q;
    gtt_d    = gtt_q;
    gtc_d    = gtc_q;
    nzhi_d   = nzhi_q;
    lowone_d = lowone_q;
    lsb_d    = lsb_q;
    ovf_d    = ovf_q;
    done_d   = 1'b0;
    n_d      = n_q;
    top_d    = top_q;
    steps_d  = steps_q;
    unique case (state_q)
      SER_IDLE: begin
        if (start_i) begin
          n_d     = PW'(seed_i);
          top_d   = PW'(seed_i);
          steps_d = '0;
          op_d    = OP_COPY;
          dig_d   = '0;
          carry_d = 2'd0;
          pmsb_d  = 1'b0;
          ovf_d   = 1'b0;
          state_d = SER_PASS;
        end
      end
      SER_PASS: begin
        n_d     = {out_dig, n_q[NDIG-1:1]};
        top_d   = {top_q[0], top_q[NDIG-1:1]};
        carry_d = sum[DIGIT_W+1:DIGIT_W];
        pmsb_d  = d0[DIGIT_W-1];
        if (out_dig > top_q[0]) begin
          gtt_d = 1'b1;
        end else if (out_dig < top_q[0]) begin
          gtt_d = 1'b0;
        end else begin
          gtt_d = gtt_b;
        end
        if (out_dig > CLIM_D[dig_q]) begin
          gtc_d = 1'b1;
        end else if (out_dig < CLIM_D[dig_q]) begin
          gtc_d = 1'b0;
        end else begin
          gtc_d = gtc_b;
        end
        if (first) begin
          lowone_d = (out_dig == DIGIT_W'(1));
          lsb_d    = out_dig[0];
          nzhi_d   = 1'b0;
        end else begin
          nzhi_d = nzhi_q | (out_dig != '0);
        end
        dig_d = dig_q + 1'b1;
        if (dig_q == LAST) begin
          state_d = SER_DECIDE;
          if (op_q != OP_COPY) begin
            steps_d = steps_q + 1'b1;
          end
        end
      end
      SER_DECIDE: begin
        if (gtt_q) begin
          top_d = n_q;
        end
        dig_d   = '0;
        carry_d = 2'd0;
        pmsb_d  = 1'b0;
        if (lowone_q && !nzhi_q) begin
          done_d  = 1'b1;
          state_d = SER_IDLE;
        end else if (steps_q == '1) begin
          done_d  = 1'b1;
          ovf_d   = 1'b1;
          state_d = SER_IDLE;
        end else if (!lsb_q) begin
          op_d    = OP_HALF;
          state_d = SER_PASS;
        end else if (gtc_q) begin
          done_d  = 1'b1;
          ovf_d   = 1'b1;
          state_d = SER_IDLE;
        end else begin
          op_d    = OP_TRIPLE;
          carry_d = 2'd1;
          state_d = SER_PASS;
        end
      end
      default: state_d = SER_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SER_IDLE;
      op_q     <= OP_COPY;
      dig_q    <= '0;
      carry_q  <= 2'd0;
      pmsb_q   <= 1'b0;
      gtt_q    <= 1'b0;
      gtc_q    <= 1'b0;
      nzhi_q   <= 1'b0;
      lowone_q <= 1'b0;
      lsb_q    <= 1'b0;
      ovf_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      dig_q    <= dig_d;
      carry_q  <= carry_d;
      pmsb_q   <= pmsb_d;
      gtt_q    <= gtt_d;
      gtc_q    <= gtc_d;
      nzhi_q   <= nzhi_d;
      lowone_q <= lowone_d;
      lsb_q    <= lsb_d;
      ovf_q    <= ovf_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    top_q   <= top_d;
    steps_q <= steps_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;
  assign len_o       = steps_q;
  assign peak_o      = top_q;

endmodule

[rtl/collatz_pack_max_search_unit.sv]
// Top level of the Collatz pack search block: request handshake, pack loop,
// best-length and best-height tracking, and the registered result.
// Depends on cpms_pkg and cpms_series.

// A request carries a start index i. The block walks the odd seeds 2*i+1,
// 2*i+3, ... for series_count seeds (0 counts as 1, anything above 1024 as
// 1024) and returns one result: the longest series with the earliest seed that
// reached it, the highest value reached with the earliest seed that reached it,
// and a flag that is set when any series was cut short because 3n+1 would leave
// the value range or the step counter would run past its top. Values travel
// through a digit-serial engine, eight bits per clock; one Collatz step is a
// pass over all NDIG eight-bit digits of a value followed by a decision
// (VALUE_WIDTH-1 bits; eight digits at the default width). series_count
// resets to 100. Requests are taken one at a time: in_stall_o is high from
// acceptance until the result has moved into the output register, and the
// next request is taken while a finished result still waits there.
// series_count is written with cfg_we_i and should only change while the
// block is idle.
module collatz_pack_max_search_unit #(
  parameter int unsigned VALUE_WIDTH  = 64,
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cpms_pkg::CNT_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [cpms_pkg::START_W-1:0]     start_index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [cpms_pkg::LEN_OUT_W-1:0]   max_length_o,
  output logic [cpms_pkg::SEED_W-1:0]      seed_of_max_length_o,
  output logic [cpms_pkg::HEIGHT_W-1:0]    max_height_o,
  output logic [cpms_pkg::SEED_W-1:0]      seed_of_max_height_o,
  output logic                             overflow_o
);
  import cpms_pkg::*;

  localparam int unsigned VW_N   = VALUE_WIDTH - 1;
  localparam int unsigned NDIG   = (VW_N + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned DIG_IW = $clog2(NDIG);
  localparam logic [DIG_IW-1:0] LAST = DIG_IW'(NDIG - 1);
  localparam int unsigned LX = (LENGTH_WIDTH > LEN_OUT_W) ? LENGTH_WIDTH : LEN_OUT_W;

  top_state_e                    state_q, state_d;
  logic [CNT_W-1:0]              scnt_q;
  logic [CNT_W-1:0]              rem_q, rem_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [DIG_IW-1:0]             dig_q, dig_d;
  logic                          gt_q, gt_d;
  logic                          start_q, start_d;
  logic                          ovf_q, ovf_d;
  logic [LENGTH_WIDTH-1:0]       best_len_q, best_len_d;
  logic [SEED_W-1:0]             best_ls_q, best_ls_d;
  logic [NDIG-1:0][DIGIT_W-1:0]  best_h_q, best_h_d;
  logic [SEED_W-1:0]             best_hs_q, best_hs_d;

  logic                          out_valid_q, out_valid_d;
  logic [LEN_OUT_W-1:0]          out_len_q, out_len_d;
  logic [SEED_W-1:0]             out_ls_q, out_ls_d;
  logic [HEIGHT_W-1:0]           out_h_q, out_h_d;
  logic [SEED_W-1:0]             out_hs_q, out_hs_d;
  logic                          out_ovf_q, out_ovf_d;

  ser_stat_t                     ser_stat;
  logic [LENGTH_WIDTH-1:0]       ser_len;
  logic [NDIG-1:0][DIGIT_W-1:0]  ser_peak;

  logic [SEED_W-1:0]             seed;
  logic [CNT_W-1:0]              cnt_eff;
  logic [LX-1:0]                 len_x;
  logic [DIGIT_W-1:0]            pd, bd;
  logic                          gt_b;

  // Seeds are odd by construction: the index with a one appended.
  assign seed = {idx_q, 1'b1};

  cpms_series #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_series (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .seed_i (seed),
    .stat_o (ser_stat),
    .len_o  (ser_len),
    .peak_o (ser_peak)
  );

  always_comb begin
    if (scnt_q == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (scnt_q > CNT_MAX) begin
      cnt_eff = CNT_MAX;
    end else begin
      cnt_eff = scnt_q;
    end
    // Lengths wider than the result field saturate.
    len_x = LX'(best_len_q);
    pd    = ser_peak[dig_q];
    bd    = best_h_q[dig_q];
    gt_b  = (dig_q == '0) ? 1'b0 : gt_q;
  end

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    dig_d       = dig_q;
    gt_d        = gt_q;
    start_d     = 1'b0;
    ovf_d       = ovf_q;
    best_len_d  = best_len_q;
    best_ls_d   = best_ls_q;
    best_h_d    = best_h_q;
    best_hs_d   = best_hs_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_len_d   = out_len_q;
    out_ls_d    = out_ls_q;
    out_h_d     = out_h_q;
    out_hs_d    = out_hs_q;
    out_ovf_d   = out_ovf_q;
    unique case (state_q)
      T_IDLE: begin
        if (in_valid_i) begin
          idx_d      = IDX_W'(start_index_i);
          rem_d      = cnt_eff;
          ovf_d      = 1'b0;
          best_len_d = '0;
          best_ls_d  = '0;
          best_h_d   = '0;
          best_hs_d  = '0;
          start_d    = 1'b1;
          state_d    = T_RUN;
        end
      end
      T_RUN: begin
        if (ser_stat.done) begin
          dig_d   = '0;
          state_d = T_CMP;
        end
      end
      T_CMP: begin
        // Least significant digit first: the last differing digit decides.
        if (pd > bd) begin
          gt_d = 1'b1;
        end else if (pd < bd) begin
          gt_d = 1'b0;
        end else begin
          gt_d = gt_b;
        end
        dig_d = dig_q + 1'b1;
        if (dig_q == LAST) begin
          state_d = T_UPD;
        end
      end
      T_UPD: begin
        if (gt_q) begin
          best_h_d  = ser_peak;
          best_hs_d = seed;
        end
        if (ser_len > best_len_q) begin
          best_len_d = ser_len;
          best_ls_d  = seed;
        end
        ovf_d = ovf_q | ser_stat.ovf;
        if (rem_q == CNT_W'(1)) begin
          state_d = T_DONE;
        end else begin
          rem_d   = rem_q - 1'b1;
          idx_d   = idx_q + 1'b1;
          start_d = 1'b1;
          state_d = T_RUN;
        end
      end
      T_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_len_d   = (len_x > LX'(16'hFFFF)) ? 16'hFFFF : len_x[LEN_OUT_W-1:0];
          out_ls_d    = best_ls_q;
          out_h_d     = HEIGHT_W'(best_h_q);
          out_hs_d    = best_hs_q;
          out_ovf_d   = ovf_q;
          state_d     = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      scnt_q      <= CNT_RESET;
      rem_q       <= '0;
      dig_q       <= '0;
      gt_q        <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      dig_q       <= dig_d;
      gt_q        <= gt_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        scnt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    ovf_q      <= ovf_d;
    best_len_q <= best_len_d;
    best_ls_q  <= best_ls_d;
    best_h_q   <= best_h_d;
    best_hs_q  <= best_hs_d;
    out_len_q  <= out_len_d;
    out_ls_q   <= out_ls_d;
    out_h_q    <= out_h_d;
    out_hs_q   <= out_hs_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign in_stall_o           = (state_q != T_IDLE);
  assign out_valid_o          = out_valid_q;
  assign max_length_o         = out_len_q;
  assign seed_of_max_length_o = out_ls_q;
  assign max_height_o         = out_h_q;
  assign seed_of_max_height_o = out_hs_q;
  assign overflow_o           = out_ovf_q;

endmodule

[rtl/cpms_checker.sv]
// Port-level checker of the Collatz pack search block and its bind to the top level.
// Depends on cpms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpms_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_we_i,
  input logic [cpms_pkg::CNT_W-1:0]       cfg_wdata_i,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [cpms_pkg::START_W-1:0]     start_index_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [cpms_pkg::LEN_OUT_W-1:0]   max_length_o,
  input logic [cpms_pkg::SEED_W-1:0]      seed_of_max_length_o,
  input logic [cpms_pkg::HEIGHT_W-1:0]    max_height_o,
  input logic [cpms_pkg::SEED_W-1:0]      seed_of_max_height_o,
  input logic                             overflow_o
);
  import cpms_pkg::*;

  // The block comes out of reset idle with no result pending.
  `CPMS_ASSERT_IN_RESET(a_reset_idle, clk_i, rst_ni, !out_valid_o && !in_stall_o)

  // An accepted request keeps the block busy in the following cycle.
  `CPMS_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)

  // Every pack reaches a positive height, first seen at an odd seed.
  `CPMS_ASSERT(a_height_seed_odd, clk_i, rst_ni, out_valid_o |-> max_height_o != 0 && seed_of_max_height_o[0])

  // A zero length is reported with seed 0 and a positive length never is.
  `CPMS_ASSERT(a_len_seed_pair, clk_i, rst_ni, out_valid_o |-> (seed_of_max_length_o == 0) == (max_length_o == 0))

  // A stalled result stays valid and keeps its length.
  `CPMS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(max_length_o))

endmodule

bind collatz_pack_max_search_unit cpms_checker u_cpms_checker (.*);

[tb/tb_collatz_pack_max_search_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for collatz_pack_max_search_unit: a queue-fed request driver,
// a result monitor and a built-in pack search predictor. Depends on cpms_pkg and the RTL.
module tb_collatz_pack_max_search_unit;

  import cpms_pkg::*;

  localparam int unsigned VAL_W = 64;
  localparam int unsigned LEN_W = 16;

  // Largest value a series may hold and the step count at which a series is cut off.
  localparam logic [63:0] VALUE_TOP = (64'd1 << (VAL_W - 1)) - 64'd1;
  localparam logic [63:0] STEP_TOP  = (64'd1 << LEN_W) - 64'd1;

  // A single pack of 1024 low seeds runs without any handshake until its result is out,
  // so the watchdog limit leaves generous room above the run time of such a pack.
  localparam int unsigned QUIET_LIMIT = 4000000;

  // Seed 8528817511 climbs past 2^63 on its way down, so its series has to stop early.
  localparam logic [START_W-1:0] CLIMBER_INDEX = 32'd4264408755;

  typedef struct packed {
    logic [LEN_OUT_W-1:0] len;
    logic [SEED_W-1:0]    len_seed;
    logic [HEIGHT_W-1:0]  height;
    logic [SEED_W-1:0]    height_seed;
    logic                 ovf;
  } pack_result_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b1;
  logic                 cfg_we_i = 1'b0;
  logic [CNT_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [START_W-1:0]   start_index_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [LEN_OUT_W-1:0] max_length_o;
  logic [SEED_W-1:0]    seed_of_max_length_o;
  logic [HEIGHT_W-1:0]  max_height_o;
  logic [SEED_W-1:0]    seed_of_max_height_o;
  logic                 overflow_o;

  // Start indexes waiting to be sent, and the pack results predicted for accepted items.
  logic [START_W-1:0] start_index_q[$];
  pack_result_t       pack_results_q[$];

  // Copy of the series_count register as the testbench last wrote it.
  logic [CNT_W-1:0] series_count_q = CNT_RESET;

  int unsigned send_idle_pct  = 38;
  int unsigned recv_stall_pct = 45;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  collatz_pack_max_search_unit #(
    .VALUE_WIDTH (VAL_W),
    .LENGTH_WIDTH(LEN_W)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .start_index_i       (start_index_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .max_length_o        (max_length_o),
    .seed_of_max_length_o(seed_of_max_length_o),
    .max_height_o        (max_height_o),
    .seed_of_max_height_o(seed_of_max_height_o),
    .overflow_o          (overflow_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Walks the odd seeds of one request and keeps the longest and the highest series. A
  // later seed only wins when it is strictly better, so ties stay with the earliest seed.
  // A series stops early when 3n+1 would leave the value range or the step counter hits
  // its top; it still competes with the length and peak it had reached by then.
  function automatic pack_result_t search_pack(input logic [START_W-1:0] first,
                                               input logic [CNT_W-1:0] count);
    logic [63:0]  seeds, seed, n, top, steps, best_len, best_h;
    logic [SEED_W-1:0] best_len_seed, best_h_seed;
    logic         ovf, stopped;
    int unsigned  k;
    pack_result_t r;
    // A count of zero means one seed, anything above the maximum means the maximum.
    if (count == '0) begin
      seeds = 64'd1;
    end else if (count > CNT_MAX) begin
      seeds = 64'(CNT_MAX);
    end else begin
      seeds = 64'(count);
    end
    best_len      = '0;
    best_len_seed = '0;
    best_h        = '0;
    best_h_seed   = '0;
    ovf           = 1'b0;
    for (k = 0; 64'(k) < seeds; k++) begin
      seed    = 64'd2 * (64'(first) + 64'(k)) + 64'd1;
      n       = seed;
      top     = seed;
      steps   = '0;
      stopped = 1'b0;
      while (n != 64'd1 && !stopped) begin
        if (steps >= STEP_TOP) begin
          stopped = 1'b1;
        end else if (!n[0]) begin
          n = n >> 1;
        end else if (n > (VALUE_TOP - 64'd1) / 64'd3) begin
          stopped = 1'b1;
        end else begin
          n = 64'd3 * n + 64'd1;
        end
        if (!stopped) begin
          if (n > top) begin
            top = n;
          end
          steps++;
        end
      end
      if (stopped) begin
        ovf = 1'b1;
      end
      if (best_len < steps) begin
        best_len      = steps;
        best_len_seed = seed[SEED_W-1:0];
      end
      if (best_h < top) begin
        best_h      = top;
        best_h_seed = seed[SEED_W-1:0];
      end
    end
    // Only a seed of 1 has no steps, so a pack of just that seed reports length 0, seed 0.
    r.len         = (best_len > 64'd65535) ? 16'hFFFF : best_len[LEN_OUT_W-1:0];
    r.len_seed    = best_len_seed;
    r.height      = best_h[HEIGHT_W-1:0];
    r.height_seed = best_h_seed;
    r.ovf         = ovf;
    return r;
  endfunction

  function automatic bit field_ok(input string fname, input logic [63:0] exp_v,
                                  input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, exp_v,
               act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Driver: when an item is accepted its result is predicted right away, with the
  // register value in force at that moment. A stalled item is held untouched; once the
  // slot is free the next item goes out unless the sender decides to idle this cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pack_results_q.push_back(search_pack(start_index_i, series_count_q));
        void'(start_index_q.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (start_index_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i    <= 1'b1;
          start_index_i <= start_index_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted result is matched field by field against the oldest
  // prediction. The receiver stall is redrawn every cycle.
  always @(posedge clk_i) begin
    pack_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pack_results_q.size() == 0) begin
          $display("%0t ns: result arrived with no item outstanding", $time);
          mismatches++;
        end else begin
          want = pack_results_q.pop_front();
          if (!field_ok("max_length", 64'(want.len), 64'(max_length_o))) mismatches++;
          if (!field_ok("seed_of_max_length", 64'(want.len_seed),
                        64'(seed_of_max_length_o))) mismatches++;
          if (!field_ok("max_height", 64'(want.height), 64'(max_height_o))) mismatches++;
          if (!field_ok("seed_of_max_height", 64'(want.height_seed),
                        64'(seed_of_max_height_o))) mismatches++;
          if (!field_ok("overflow", 64'(want.ovf), 64'(overflow_o))) mismatches++;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Waits until every queued item has been sent and every result has come back; the block
  // makes exactly one result per item, so it is idle then.
  task automatic drain_block();
    while (start_index_q.size() != 0 || pack_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_series_count(input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i       <= 1'b1;
    cfg_wdata_i    <= value;
    series_count_q = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly full-range indexes, with some near zero and some near the top of the field.
  function automatic logic [START_W-1:0] random_start();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      return START_W'($urandom_range(1000));
    end else if (pick < 30) begin
      return 32'hFFFF_FFFF - START_W'($urandom_range(1000));
    end
    return START_W'($urandom);
  endfunction

  initial begin
    int unsigned phase, chunk, j;
    // The falling reset edge at time zero clears the block before the first clock edge.
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of the register: a pack of 100 seeds starting at 1.
    start_index_q.push_back(32'd0);
    drain_block();

    // Zero counts as one seed. Seed 1 alone has no positive length; the top index gives
    // the largest single seed; the climber overflows the value range.
    write_series_count(11'd0);
    start_index_q.push_back(32'd0);
    start_index_q.push_back(32'hFFFF_FFFF);
    start_index_q.push_back(CLIMBER_INDEX);
    start_index_q.push_back(32'd1);
    start_index_q.push_back(32'd13);
    drain_block();

    write_series_count(11'd1);
    start_index_q.push_back(32'd0);
    start_index_q.push_back(32'h8000_0000);
    start_index_q.push_back(32'h7FFF_FFFF);
    start_index_q.push_back(CLIMBER_INDEX);
    drain_block();

    // All register bits set: clamped to the largest pack, from seed 1 upward.
    write_series_count(11'h7FF);
    start_index_q.push_back(32'd0);
    drain_block();

    // Packs that run past the top index (seeds wider than 33 bits), and a pack in which
    // the climber sits between normal seeds so the flag comes from one series only.
    write_series_count(11'd3);
    start_index_q.push_back(32'hFFFF_FFFE);
    start_index_q.push_back(CLIMBER_INDEX - 32'd1);
    start_index_q.push_back(32'h5555_5555);
    start_index_q.push_back(32'hAAAA_AAAA);
    start_index_q.push_back(32'd0);
    drain_block();

    // Random part in three stretches: receiver stalls more, sender idles more, then
    // neither holds back. Each stretch draws three pack sizes from 1 to 4 at random.
    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct  = 45;
        recv_stall_pct = 38;
      end else if (phase == 2) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      for (chunk = 0; chunk < 3; chunk++) begin
        write_series_count(CNT_W'($urandom_range(1, 4)));
        for (j = 0; j < 11; j++) begin
          start_index_q.push_back(random_start());
        end
        drain_block();
      end
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pack_results_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
